// ===== hdl/stc_pkg.sv =====
`default_nettype none

package stc_pkg;

	localparam int KEY_BITS = 10;
	localparam int OUT_BITS = 32;
	localparam int DEF_LEAVES = 1024;
	localparam int DEF_COUNT_BITS = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS,
		ST_QRY,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/stc_if.sv =====
`default_nettype none

interface stc_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [stc_pkg::KEY_BITS-1:0]  key_low;
	logic [stc_pkg::KEY_BITS-1:0]  key_high;

	modport source (output valid, mode, key_low, key_high, input ready);
	modport sink (input valid, mode, key_low, key_high, output ready);
endinterface

interface stc_resp_if;
	logic                          valid;
	logic                          ready;
	logic [stc_pkg::OUT_BITS-1:0]  range_count;

	modport source (output valid, range_count, input ready);
	modport sink (input valid, range_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/stc_ram.sv =====
`default_nettype none

module stc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== hdl/segment_tree_range_count_top.sv =====
`default_nettype none

// Counting segment tree over LEAVES keys, held in one two-read, one-write RAM of
// 2*LEAVES words. An insert transaction adds one, saturating, to a key's leaf and
// all its ancestors; it issues one read per level, writes each node back in the
// cycle after its read, and gives no result.
// A query transaction walks both range ends upward, one level per cycle, reading up
// to two nodes per level until the two ends meet, then loads its count into the
// output register, waiting while an earlier count is still held there. A key at
// or above LEAVES is ignored on insert, a high key at or above LEAVES is clamped,
// and an empty range returns 0.
// After reset the RAM is cleared one word per cycle, all 2*LEAVES words, before
// the first transaction is accepted.
module segment_tree_range_count_top #(
	parameter int LEAVES = stc_pkg::DEF_LEAVES,
	parameter int COUNT_BITS = stc_pkg::DEF_COUNT_BITS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stc_req_if.sink     req,
	stc_resp_if.source  resp
);

	localparam int DEPTH = 2 * LEAVES;
	localparam int AW = $clog2(DEPTH);
	localparam int IDX_W = $clog2(DEPTH + 1);
	localparam int CW = ((IDX_W > stc_pkg::KEY_BITS) ? IDX_W : stc_pkg::KEY_BITS) + 1;
	localparam int EXT_W = (COUNT_BITS > stc_pkg::OUT_BITS) ? COUNT_BITS : stc_pkg::OUT_BITS;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [stc_pkg::OUT_BITS-1:0] OMAX = '1;

	stc_pkg::state_t state_q, state_d;

	logic [AW-1:0]               clr_q;
	logic [IDX_W-1:0]            cur_q;
	logic [IDX_W-1:0]            r_q;
	logic                        wr_pend_s1;
	logic [AW-1:0]               wr_addr_s1;
	logic                        rd_a_s1;
	logic                        rd_b_s1;
	logic [COUNT_BITS-1:0]       sum_q;
	logic                        out_valid_q;
	logic [stc_pkg::OUT_BITS-1:0] out_count_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [AW-1:0]         rd_addr_a;
	logic [AW-1:0]         rd_addr_b;
	logic [COUNT_BITS-1:0] rdata_a;
	logic [COUNT_BITS-1:0] rdata_b;

	logic                  accept;
	logic                  key_ok;
	logic [CW-1:0]         lo_w;
	logic [CW-1:0]         hi_w;
	logic                  empty_rng;
	logic [IDX_W-1:0]      l_init;
	logic [IDX_W-1:0]      r_init;
	logic [IDX_W-1:0]      leaf_idx;
	logic                  walk_on;
	logic [COUNT_BITS-1:0] inc_val;
	logic [COUNT_BITS+1:0] sum3;
	logic [COUNT_BITS-1:0] sum_d;
	logic [EXT_W-1:0]      sum_ext;
	logic [stc_pkg::OUT_BITS-1:0] out_d;
	logic                  out_free;

	stc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (rd_addr_a),
		.rdata_a (rdata_a),
		.raddr_b (rd_addr_b),
		.rdata_b (rdata_b)
	);

	assign accept = req.valid && req.ready;
	assign key_ok = CW'(req.key_low) < CW'(LEAVES);
	assign lo_w = CW'(req.key_low);
	assign hi_w = (CW'(req.key_high) >= CW'(LEAVES)) ? CW'(LEAVES - 1) : CW'(req.key_high);
	assign empty_rng = lo_w > hi_w;
	assign leaf_idx = IDX_W'(CW'(LEAVES) + lo_w);
	assign l_init = IDX_W'(CW'(LEAVES) + lo_w);
	assign r_init = IDX_W'(CW'(LEAVES) + hi_w + CW'(1));
	assign walk_on = cur_q < r_q;
	assign out_free = !out_valid_q || resp.ready;

	assign inc_val = (rdata_a == CMAX) ? rdata_a : rdata_a + COUNT_BITS'(1);
	assign sum3 = {2'b00, sum_q}
		+ (rd_a_s1 ? {2'b00, rdata_a} : '0)
		+ (rd_b_s1 ? {2'b00, rdata_b} : '0);
	assign sum_d = (sum3 > {2'b00, CMAX}) ? CMAX : sum3[COUNT_BITS-1:0];
	assign sum_ext = EXT_W'(sum_q);
	assign out_d = (sum_ext > EXT_W'(OMAX)) ? OMAX : sum_ext[stc_pkg::OUT_BITS-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			stc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = stc_pkg::ST_IDLE;
				end
			end
			stc_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.mode == stc_pkg::MODE_INSERT) begin
						if (key_ok) begin
							state_d = stc_pkg::ST_INS;
						end
					end else if (empty_rng) begin
						state_d = stc_pkg::ST_DONE;
					end else begin
						state_d = stc_pkg::ST_QRY;
					end
				end
			end
			stc_pkg::ST_INS: begin
				if (cur_q == '0) begin
					state_d = stc_pkg::ST_IDLE;
				end
			end
			stc_pkg::ST_QRY: begin
				if (!walk_on) begin
					state_d = stc_pkg::ST_DONE;
				end
			end
			stc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = stc_pkg::ST_IDLE;
				end
			end
			default: state_d = stc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we = wr_pend_s1;
		ram_waddr = wr_addr_s1;
		ram_wdata = inc_val;
		rd_addr_a = cur_q[AW-1:0];
		rd_addr_b = AW'(r_q - IDX_W'(1));
		case (state_q)
			stc_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			stc_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stc_pkg::ST_CLEAR;
			clr_q <= '0;
			wr_pend_s1 <= 1'b0;
			rd_a_s1 <= 1'b0;
			rd_b_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == stc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			wr_pend_s1 <= (state_q == stc_pkg::ST_INS) && (cur_q != '0);
			rd_a_s1 <= (state_q == stc_pkg::ST_QRY) && walk_on && cur_q[0];
			rd_b_s1 <= (state_q == stc_pkg::ST_QRY) && walk_on && r_q[0];
			if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == stc_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cur_q[AW-1:0];
		case (state_q)
			stc_pkg::ST_IDLE: begin
				sum_q <= '0;
				if (req.mode == stc_pkg::MODE_INSERT) begin
					cur_q <= leaf_idx;
				end else begin
					cur_q <= l_init;
					r_q <= r_init;
				end
			end
			stc_pkg::ST_INS: begin
				cur_q <= cur_q >> 1;
			end
			stc_pkg::ST_QRY: begin
				sum_q <= sum_d;
				if (walk_on) begin
					cur_q <= IDX_W'((CW'(cur_q) + CW'(cur_q[0])) >> 1);
					r_q <= r_q >> 1;
				end
			end
			stc_pkg::ST_DONE: begin
				if (out_free) begin
					out_count_q <= out_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign resp.valid = out_valid_q;
	assign resp.range_count = out_count_q;

`ifndef SYNTHESIS
	a_no_wr_rd_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_pend_s1 && state_q == stc_pkg::ST_INS && cur_q != '0)
			|-> (wr_addr_s1 != cur_q[AW-1:0]))
		else $error("insert writes back the node it is reading");
	a_idle_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !wr_pend_s1)
		else $error("transaction accepted while a write-back is pending");
	a_qry_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stc_pkg::ST_QRY) |-> !wr_pend_s1)
		else $error("query walk overlaps an insert write-back");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stc_pkg::ST_DONE && out_free) |=> out_valid_q)
		else $error("finished query did not load the output register");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stc_pkg::ST_CLEAR) |-> (!req.ready && ram_we))
		else $error("clearing pass not exclusive");
`endif

endmodule

`default_nettype wire
